// ----- rtl/t2dsg_pkg.sv -----
// ----------------------------------------------------------------------------
// t2dsg_pkg
// Shared types, constants and helper functions of the 2D turtle segment
// generator.
// ----------------------------------------------------------------------------
package t2dsg_pkg;

    localparam int STACK_DEPTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [63:0] Q30_TWO_PI  = 64'sd6746518852;
    localparam logic signed [63:0] Q30_PI      = 64'sd3373259426;
    localparam logic signed [63:0] Q30_HALF_PI = 64'sd1686629713;
    localparam logic signed [33:0] Q30_GAIN    = 34'sd652032874;

    localparam logic [30:0] STEP_LENGTH_RST = 31'd327680;
    localparam logic [17:0] TURN_COS_RST    = 18'd60547;
    localparam logic [17:0] TURN_SIN_RST    = 18'd25080;
    localparam logic [31:0] HEAD_X_RST      = 32'd327680;
    localparam logic [31:0] HEAD_Y_RST      = 32'd0;
    localparam logic [31:0] COLOR_RST       = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        REG_STEP_LENGTH = 3'd0,
        REG_TURN_COS    = 3'd1,
        REG_TURN_SIN    = 3'd2,
        REG_HEAD_X      = 3'd3,
        REG_HEAD_Y      = 3'd4,
        REG_COLOR       = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        FUNC_MOVE   = 3'd0,
        FUNC_LEFT   = 3'd1,
        FUNC_RIGHT  = 3'd2,
        FUNC_PUSH   = 3'd3,
        FUNC_POP    = 3'd4,
        FUNC_COLOR  = 3'd5,
        FUNC_IGNORE = 3'd6
    } func_t;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:    return 34'sd843314857;
            5'd1:    return 34'sd497837829;
            5'd2:    return 34'sd263043837;
            5'd3:    return 34'sd133525159;
            5'd4:    return 34'sd67021687;
            5'd5:    return 34'sd33543516;
            5'd6:    return 34'sd16775851;
            5'd7:    return 34'sd8388437;
            5'd8:    return 34'sd4194283;
            5'd9:    return 34'sd2097149;
            5'd10:   return 34'sd1048576;
            5'd11:   return 34'sd524288;
            5'd12:   return 34'sd262144;
            5'd13:   return 34'sd131072;
            5'd14:   return 34'sd65536;
            5'd15:   return 34'sd32768;
            5'd16:   return 34'sd16384;
            5'd17:   return 34'sd8192;
            5'd18:   return 34'sd4096;
            5'd19:   return 34'sd2048;
            5'd20:   return 34'sd1024;
            5'd21:   return 34'sd512;
            5'd22:   return 34'sd256;
            5'd23:   return 34'sd128;
            default: return 34'sd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    function automatic logic [7:0] color_byte(input logic [31:0] raw);
        if (raw[31]) begin
            return 8'd0;
        end else if (raw[30:16] > 15'd255) begin
            return 8'hFF;
        end else begin
            return raw[23:16];
        end
    endfunction

endpackage

// ----- rtl/turtle_2d_segment_generator.sv -----
// ----------------------------------------------------------------------------
// turtle_2d_segment_generator
// Turtle command interpreter: position, heading, pen colour and a save stack
// held in a synchronous memory; emits line segments and overflow reports.
// ----------------------------------------------------------------------------
// One request is taken at a time. A move and a default turn are both built
// on one shared 32x32 multiplier used for two or four products. A turn by an
// argument angle runs a modulo-2pi reduction, then one CORDIC iteration per
// cycle, then the rotation. Pop waits on the registered read of the stack
// memory. A result passes through the output register.
module turtle_2d_segment_generator #(
    parameter int STACK_DEPTH  = t2dsg_pkg::STACK_DEPTH_DEF,
    parameter int CORDIC_STEPS = t2dsg_pkg::CORDIC_STEPS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // arg_count[2:0], arg_a[34:3], arg_b[66:35], arg_c[98:67], arg_d[130:99]
    input  logic [135:0] s_tdata,
    // first[0], func[3:1]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // start_x[31:0], start_y[63:32], end_x[95:64], end_y[127:96],
    // red[135:128], green[143:136], blue[151:144], alpha[159:152]
    output logic [159:0] m_tdata,
    // kind[0]
    output logic [0:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int TW = $clog2(STACK_DEPTH + 1);
    localparam int CW = $clog2(CORDIC_STEPS);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_EXEC = 10'b00_0000_0010,
        S_MOD  = 10'b00_0000_0100,
        S_FOLD = 10'b00_0000_1000,
        S_CORD = 10'b00_0001_0000,
        S_CSN  = 10'b00_0010_0000,
        S_MUL  = 10'b00_0100_0000,
        S_ACC  = 10'b00_1000_0000,
        S_POP  = 10'b01_0000_0000,
        S_OUT  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;

    logic [30:0] step_length_reg;
    logic [17:0] turn_cos_reg, turn_sin_reg;
    logic [31:0] start_hx_reg, start_hy_reg, start_color_reg;

    logic [2:0]  func_reg, cnt_reg;
    logic [31:0] arg_a_reg, arg_b_reg, arg_c_reg, arg_d_reg;

    logic signed [31:0] pos_x_reg, pos_y_reg, head_x_reg, head_y_reg;
    logic [31:0]        color_reg;
    logic [TW-1:0]      top_reg;

    logic signed [31:0] len_reg;
    logic signed [18:0] rot_c_reg, rot_s_reg;
    logic               mode_move_reg;
    logic [1:0]         k_reg;
    logic signed [63:0] prod_reg, acc_reg;
    logic signed [31:0] tmp_x_reg;

    logic [45:0]        mag_reg;
    logic               neg_reg;
    logic [3:0]         md_k_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic [CW-1:0]      it_reg;

    logic               res_kind_reg;
    logic [159:0]       res_data_reg;
    logic               m_tvalid_reg, out_kind_reg;
    logic [159:0]       out_data_reg;

    logic [159:0] mem [STACK_DEPTH];
    logic [159:0] rd_q_reg;

    logic               in_acc, cfg_wr, mem_we, rd_en;
    logic [TW-1:0]      top_m1;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [46:0]        mod_sub;
    logic signed [63:0] z64, z_wrap;
    logic signed [34:0] z_fold;
    logic               z_flip;
    logic signed [33:0] cdx, cdy, atan_v;
    logic signed [33:0] fin_x, fin_y;
    logic signed [33:0] rnd_x, rnd_y;
    logic signed [32:0] ang33, abs33;
    logic signed [63:0] move_sum, rot_diff, rot_sum;

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    assign mem_we = (state_reg == S_EXEC) && (func_reg == t2dsg_pkg::FUNC_PUSH)
                    && (top_reg != TW'(STACK_DEPTH));
    assign rd_en  = (state_reg == S_EXEC) && (func_reg == t2dsg_pkg::FUNC_POP)
                    && (top_reg != '0);
    assign top_m1 = top_reg - 1'b1;

    assign mul_a = k_reg[0] ? head_y_reg : head_x_reg;
    assign mul_b = mode_move_reg ? len_reg
                 : ((k_reg[0] ^ k_reg[1]) ? 32'(rot_s_reg) : 32'(rot_c_reg));
    assign mul_p = mul_a * mul_b;

    assign move_sum = (k_reg[0] ? 64'(pos_y_reg) : 64'(pos_x_reg)) + (prod_reg >>> 16);
    assign rot_diff = (acc_reg - prod_reg) >>> 16;
    assign rot_sum  = (acc_reg + prod_reg) >>> 16;

    assign mod_sub = {1'b0, mag_reg} - (47'(t2dsg_pkg::Q30_TWO_PI) << md_k_reg);

    assign ang33 = (func_reg == t2dsg_pkg::FUNC_RIGHT) ? -$signed({arg_a_reg[31], arg_a_reg})
                                                       : $signed({arg_a_reg[31], arg_a_reg});
    assign abs33 = ang33[32] ? -ang33 : ang33;

    always_comb begin
        z64 = neg_reg ? -$signed({18'b0, mag_reg}) : $signed({18'b0, mag_reg});
        z_wrap = z64;
        if (z64 > t2dsg_pkg::Q30_PI) begin
            z_wrap = z64 - t2dsg_pkg::Q30_TWO_PI;
        end else if (z64 < -t2dsg_pkg::Q30_PI) begin
            z_wrap = z64 + t2dsg_pkg::Q30_TWO_PI;
        end
        z_flip = 1'b0;
        z_fold = z_wrap[34:0];
        if (z_wrap > t2dsg_pkg::Q30_HALF_PI) begin
            z_fold = 35'(z_wrap - t2dsg_pkg::Q30_PI);
            z_flip = 1'b1;
        end else if (z_wrap < -t2dsg_pkg::Q30_HALF_PI) begin
            z_fold = 35'(z_wrap + t2dsg_pkg::Q30_PI);
            z_flip = 1'b1;
        end
    end

    assign cdx    = cx_reg >>> it_reg;
    assign cdy    = cy_reg >>> it_reg;
    assign atan_v = t2dsg_pkg::atan_q30(5'(it_reg));
    assign fin_x  = flip_reg ? -cx_reg : cx_reg;
    assign fin_y  = flip_reg ? -cy_reg : cy_reg;
    assign rnd_x  = (fin_x + 34'sd8192) >>> 14;
    assign rnd_y  = (fin_y + 34'sd8192) >>> 14;

    always_comb begin
        case (paddr[4:2])
            t2dsg_pkg::REG_STEP_LENGTH: prdata = {1'b0, step_length_reg};
            t2dsg_pkg::REG_TURN_COS:    prdata = {14'b0, turn_cos_reg};
            t2dsg_pkg::REG_TURN_SIN:    prdata = {14'b0, turn_sin_reg};
            t2dsg_pkg::REG_HEAD_X:      prdata = start_hx_reg;
            t2dsg_pkg::REG_HEAD_Y:      prdata = start_hy_reg;
            t2dsg_pkg::REG_COLOR:       prdata = start_color_reg;
            default:                    prdata = 32'd0;
        endcase
    end

    // stack memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[top_reg[AW-1:0]] <= {color_reg, head_y_reg, head_x_reg, pos_y_reg, pos_x_reg};
        end
        if (rd_en) begin
            rd_q_reg <= mem[top_m1[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            step_length_reg <= t2dsg_pkg::STEP_LENGTH_RST;
            turn_cos_reg    <= t2dsg_pkg::TURN_COS_RST;
            turn_sin_reg    <= t2dsg_pkg::TURN_SIN_RST;
            start_hx_reg    <= t2dsg_pkg::HEAD_X_RST;
            start_hy_reg    <= t2dsg_pkg::HEAD_Y_RST;
            start_color_reg <= t2dsg_pkg::COLOR_RST;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            head_x_reg      <= t2dsg_pkg::HEAD_X_RST;
            head_y_reg      <= t2dsg_pkg::HEAD_Y_RST;
            color_reg       <= t2dsg_pkg::COLOR_RST;
            top_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[4:2])
                    t2dsg_pkg::REG_STEP_LENGTH: step_length_reg <= pwdata[30:0];
                    t2dsg_pkg::REG_TURN_COS:    turn_cos_reg    <= pwdata[17:0];
                    t2dsg_pkg::REG_TURN_SIN:    turn_sin_reg    <= pwdata[17:0];
                    t2dsg_pkg::REG_HEAD_X:      start_hx_reg    <= pwdata;
                    t2dsg_pkg::REG_HEAD_Y:      start_hy_reg    <= pwdata;
                    t2dsg_pkg::REG_COLOR:       start_color_reg <= pwdata;
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        func_reg  <= s_tuser[3:1];
                        cnt_reg   <= s_tdata[2:0];
                        arg_a_reg <= s_tdata[34:3];
                        arg_b_reg <= s_tdata[66:35];
                        arg_c_reg <= s_tdata[98:67];
                        arg_d_reg <= s_tdata[130:99];
                        if (s_tuser[0]) begin
                            pos_x_reg  <= '0;
                            pos_y_reg  <= '0;
                            head_x_reg <= start_hx_reg;
                            head_y_reg <= start_hy_reg;
                            color_reg  <= start_color_reg;
                            top_reg    <= '0;
                        end
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    k_reg     <= 2'd0;
                    state_reg <= S_IDLE;
                    case (func_reg)
                        t2dsg_pkg::FUNC_MOVE: begin
                            len_reg       <= (cnt_reg != 3'd0) ? arg_a_reg
                                                               : {1'b0, step_length_reg};
                            mode_move_reg <= 1'b1;
                            state_reg     <= S_MUL;
                        end
                        t2dsg_pkg::FUNC_LEFT, t2dsg_pkg::FUNC_RIGHT: begin
                            mode_move_reg <= 1'b0;
                            if (cnt_reg != 3'd0) begin
                                neg_reg   <= ang33[32];
                                mag_reg   <= {abs33[31:0], 14'b0};
                                md_k_reg  <= 4'd12;
                                state_reg <= S_MOD;
                            end else begin
                                rot_c_reg <= 19'($signed(turn_cos_reg));
                                rot_s_reg <= (func_reg == t2dsg_pkg::FUNC_RIGHT)
                                             ? -19'($signed(turn_sin_reg))
                                             : 19'($signed(turn_sin_reg));
                                state_reg <= S_MUL;
                            end
                        end
                        t2dsg_pkg::FUNC_PUSH: begin
                            if (top_reg == TW'(STACK_DEPTH)) begin
                                res_kind_reg <= 1'b1;
                                res_data_reg <= '0;
                                state_reg    <= S_OUT;
                            end else begin
                                top_reg <= top_reg + 1'b1;
                            end
                        end
                        t2dsg_pkg::FUNC_POP: begin
                            if (top_reg != '0) begin
                                top_reg   <= top_m1;
                                state_reg <= S_POP;
                            end
                        end
                        t2dsg_pkg::FUNC_COLOR: begin
                            if (cnt_reg == 3'd1) begin
                                color_reg <= {{3{t2dsg_pkg::color_byte(arg_a_reg)}}, 8'hFF};
                            end else if (cnt_reg == 3'd3) begin
                                color_reg <= {t2dsg_pkg::color_byte(arg_a_reg),
                                              t2dsg_pkg::color_byte(arg_b_reg),
                                              t2dsg_pkg::color_byte(arg_c_reg), 8'hFF};
                            end else if (cnt_reg == 3'd4) begin
                                color_reg <= {t2dsg_pkg::color_byte(arg_a_reg),
                                              t2dsg_pkg::color_byte(arg_b_reg),
                                              t2dsg_pkg::color_byte(arg_c_reg),
                                              t2dsg_pkg::color_byte(arg_d_reg)};
                            end
                        end
                        default: ;
                    endcase
                end
                S_MOD: begin
                    if (!mod_sub[46]) begin
                        mag_reg <= mod_sub[45:0];
                    end
                    if (md_k_reg == 4'd0) begin
                        state_reg <= S_FOLD;
                    end else begin
                        md_k_reg <= md_k_reg - 1'b1;
                    end
                end
                S_FOLD: begin
                    cz_reg    <= z_fold[33:0];
                    flip_reg  <= z_flip;
                    cx_reg    <= t2dsg_pkg::Q30_GAIN;
                    cy_reg    <= '0;
                    it_reg    <= '0;
                    state_reg <= S_CORD;
                end
                S_CORD: begin
                    if (!cz_reg[33]) begin
                        cx_reg <= cx_reg - cdy;
                        cy_reg <= cy_reg + cdx;
                        cz_reg <= cz_reg - atan_v;
                    end else begin
                        cx_reg <= cx_reg + cdy;
                        cy_reg <= cy_reg - cdx;
                        cz_reg <= cz_reg + atan_v;
                    end
                    if (it_reg == CW'(CORDIC_STEPS - 1)) begin
                        state_reg <= S_CSN;
                    end else begin
                        it_reg <= it_reg + 1'b1;
                    end
                end
                S_CSN: begin
                    rot_c_reg <= rnd_x[18:0];
                    rot_s_reg <= rnd_y[18:0];
                    state_reg <= S_MUL;
                end
                S_MUL: begin
                    prod_reg  <= mul_p;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= S_MUL;
                    if (mode_move_reg) begin
                        if (k_reg[0]) begin
                            pos_x_reg    <= tmp_x_reg;
                            pos_y_reg    <= t2dsg_pkg::sat32(move_sum);
                            res_kind_reg <= 1'b0;
                            res_data_reg <= {color_reg[7:0], color_reg[15:8],
                                             color_reg[23:16], color_reg[31:24],
                                             t2dsg_pkg::sat32(move_sum), tmp_x_reg,
                                             pos_y_reg, pos_x_reg};
                            state_reg    <= S_OUT;
                        end else begin
                            tmp_x_reg <= t2dsg_pkg::sat32(move_sum);
                        end
                    end else begin
                        case (k_reg)
                            2'd0, 2'd2: acc_reg   <= prod_reg;
                            2'd1:       tmp_x_reg <= t2dsg_pkg::sat32(rot_diff);
                            default: begin
                                head_x_reg <= tmp_x_reg;
                                head_y_reg <= t2dsg_pkg::sat32(rot_sum);
                                state_reg  <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    {color_reg, head_y_reg, head_x_reg, pos_y_reg, pos_x_reg} <= rd_q_reg;
                    state_reg <= S_IDLE;
                end
                S_OUT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        out_kind_reg <= res_kind_reg;
                        out_data_reg <= res_data_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // checks
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= TW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("overflow report carries data");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    a_pop_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_POP |-> $past(rd_en))
        else $error("pop load without memory read");

endmodule
